### rtl/pnu_pkg.sv
// ----------------------------------------------------------------------------
// pnu_pkg
// Shared types and constants of the PNG scanline unfilter: item structs,
// filter codes, register indexes and the operation passed from front to back.
// ----------------------------------------------------------------------------
package pnu_pkg;

  localparam int unsigned MAX_ROW_BYTES = 8192;
  localparam int unsigned MAX_BPP       = 8;
  localparam int unsigned COL_W         = $clog2(MAX_ROW_BYTES);
  localparam int unsigned BPP_IDX_W     = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;
  localparam int unsigned QUEUE_DEPTH   = 4;

  localparam int unsigned ROW_BYTES_W = 14;
  localparam int unsigned BPP_W       = 4;
  localparam int unsigned ROW_COUNT_W = 16;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_IDX_W   = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROW_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BPP       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROW_COUNT = 2'd2;

  // Register values after reset.
  localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_RST = 14'd3;
  localparam logic [BPP_W-1:0]       BPP_RST       = 4'd3;
  localparam logic [ROW_COUNT_W-1:0] ROW_COUNT_RST = 16'd1;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } pnu_filter_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } pnu_in_item_t;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       last_in_row;
    logic       last_in_image;
    logic       error;
  } pnu_out_item_t;

  // Register values after range saturation.
  typedef struct packed {
    logic [ROW_BYTES_W-1:0] row_bytes;
    logic [BPP_W-1:0]       bpp;
    logic [ROW_COUNT_W-1:0] row_count;
  } pnu_cfg_t;

  // One classified data byte, ready to be reconstructed.
  typedef struct packed {
    logic [7:0]       raw;
    logic [COL_W-1:0] col;
    pnu_filter_e      filter;
    logic             first_row;
    logic             use_left;
    logic             sticky;
    logic             last_row;
    logic             last_image;
    logic             beyond;
  } pnu_op_t;

endpackage

### rtl/pnu_front.sv
// ----------------------------------------------------------------------------
// pnu_front
// Accepts stream bytes, tracks row and column positions, decodes filter bytes
// and turns each data byte into an operation for the reconstruction back end.
// ----------------------------------------------------------------------------
module pnu_front import pnu_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  pnu_cfg_t     cfg_i,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  pnu_in_item_t in_data_i,
  input  logic         q_full_i,
  output logic         push_o,
  output pnu_op_t      op_o
);

  logic [COL_W-1:0]       col_q, col_d;
  logic [ROW_COUNT_W-1:0] row_q, row_d;
  logic                   await_q, await_d;
  pnu_filter_e            filt_q, filt_d;
  logic                   first_q, first_d;
  logic                   sticky_q, sticky_d;

  logic                   accept;
  logic [COL_W-1:0]       e_col, col, rb_m1;
  logic [ROW_COUNT_W-1:0] e_row;
  logic                   e_await, e_first, e_sticky;
  pnu_filter_e            e_filt;
  logic                   beyond, end_row;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // A frame start restarts the frame before the byte is looked at.
  always_comb begin
    if (in_data_i.frame_start) begin
      e_col    = '0;
      e_row    = '0;
      e_await  = 1'b1;
      e_filt   = FILT_NONE;
      e_first  = 1'b1;
      e_sticky = 1'b0;
    end else begin
      e_col    = col_q;
      e_row    = row_q;
      e_await  = await_q;
      e_filt   = filt_q;
      e_first  = first_q;
      e_sticky = sticky_q;
    end
  end

  assign rb_m1   = COL_W'(cfg_i.row_bytes - ROW_BYTES_W'(1));
  assign col     = (e_col >= rb_m1) ? rb_m1 : e_col;
  assign end_row = (col == rb_m1);
  assign beyond  = (e_row >= cfg_i.row_count);

  always_comb begin
    col_d    = e_col;
    row_d    = e_row;
    await_d  = e_await;
    filt_d   = e_filt;
    first_d  = e_first;
    sticky_d = e_sticky;
    push_o   = 1'b0;

    op_o.raw        = in_data_i.data_byte;
    op_o.col        = col;
    op_o.filter     = e_filt;
    op_o.first_row  = e_first;
    op_o.use_left   = (col >= COL_W'(cfg_i.bpp));
    op_o.sticky     = e_sticky;
    op_o.last_row   = end_row;
    op_o.last_image = end_row &&
                      ((({1'b0, e_row}) + (ROW_COUNT_W+1)'(1)) >= {1'b0, cfg_i.row_count});
    op_o.beyond     = beyond;

    if (beyond) begin
      push_o = accept;
    end else if (e_await) begin
      await_d = 1'b0;
      if (in_data_i.data_byte <= {5'd0, FILT_PAETH}) begin
        filt_d = pnu_filter_e'(in_data_i.data_byte[2:0]);
      end else begin
        filt_d   = FILT_NONE;
        sticky_d = 1'b1;
      end
    end else begin
      push_o = accept;
      if (end_row) begin
        row_d   = e_row + ROW_COUNT_W'(1);
        first_d = 1'b0;
        col_d   = '0;
        await_d = 1'b1;
      end else begin
        col_d = col + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      await_q  <= 1'b1;
      filt_q   <= FILT_NONE;
      first_q  <= 1'b1;
      sticky_q <= 1'b0;
    end else if (accept) begin
      col_q    <= col_d;
      row_q    <= row_d;
      await_q  <= await_d;
      filt_q   <= filt_d;
      first_q  <= first_d;
      sticky_q <= sticky_d;
    end
  end

endmodule

### rtl/pnu_queue.sv
// ----------------------------------------------------------------------------
// pnu_queue
// Small register FIFO of operations between the front and the back end.
// ----------------------------------------------------------------------------
module pnu_queue import pnu_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  pnu_op_t data_i,
  output logic    full_o,
  output logic    valid_o,
  input  logic    pop_i,
  output pnu_op_t data_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  pnu_op_t            mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wptr_q, rptr_q;
  logic [PTR_W:0]     count_q;
  logic               do_push, do_pop;

  assign full_o  = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rptr_q <= rptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + (PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (PTR_W+1)'(1);
      end
    end
  end

endmodule

### rtl/pnu_back.sv
// ----------------------------------------------------------------------------
// pnu_back
// Reconstruction back end: reads the previous row from the line store, forms
// the filter predictor from the neighbour bytes and holds the result item.
// ----------------------------------------------------------------------------
module pnu_back import pnu_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [BPP_IDX_W-1:0] bpp_idx_i,
  input  logic                 q_valid_i,
  input  pnu_op_t              q_data_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pnu_out_item_t        out_data_o
);

  logic [7:0] line_mem [MAX_ROW_BYTES];
  logic [7:0] rdata_q;

  logic [7:0] left_q [MAX_BPP];
  logic [7:0] ul_q   [MAX_BPP];

  logic          b1_valid_q;
  pnu_op_t       b1_op_q;
  logic          byp_q;
  logic [7:0]    byp_data_q;

  logic          out_valid_q;
  pnu_out_item_t out_q;

  logic       advance, fire, wr_en;
  logic [7:0] up, a, b, c, pred, recon;
  logic [8:0] avg_sum;

  function automatic logic [7:0] paeth(input logic [7:0] pa_a, input logic [7:0] pa_b,
                                       input logic [7:0] pa_c);
    logic signed [10:0] p, da, db, dc;
    logic [7:0] res;
    p  = $signed({3'b0, pa_a}) + $signed({3'b0, pa_b}) - $signed({3'b0, pa_c});
    da = p - $signed({3'b0, pa_a});
    db = p - $signed({3'b0, pa_b});
    dc = p - $signed({3'b0, pa_c});
    if (da < 0) da = -da;
    if (db < 0) db = -db;
    if (dc < 0) dc = -dc;
    if (da <= db && da <= dc) begin
      res = pa_a;
    end else if (db <= dc) begin
      res = pa_b;
    end else begin
      res = pa_c;
    end
    return res;
  endfunction

  assign advance = !out_valid_q || out_ready_i;
  assign fire    = b1_valid_q && advance;
  assign q_pop_o = q_valid_i && (!b1_valid_q || fire);
  assign wr_en   = fire && !b1_op_q.beyond;

  // The byte written by the leaving item may be the one just being read.
  assign up = b1_op_q.first_row ? 8'd0 : (byp_q ? byp_data_q : rdata_q);
  assign a  = b1_op_q.use_left ? left_q[bpp_idx_i] : 8'd0;
  assign b  = up;
  assign c  = b1_op_q.use_left ? ul_q[bpp_idx_i] : 8'd0;
  assign avg_sum = {1'b0, a} + {1'b0, b};

  always_comb begin
    case (b1_op_q.filter)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = avg_sum[8:1];
      FILT_PAETH: pred = paeth(a, b, c);
      default:    pred = 8'd0;
    endcase
  end

  assign recon = b1_op_q.raw + pred;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_mem[b1_op_q.col] <= recon;
    end
    if (q_pop_o) begin
      rdata_q    <= line_mem[q_data_i.col];
      byp_q      <= wr_en && (b1_op_q.col == q_data_i.col);
      byp_data_q <= recon;
      b1_op_q    <= q_data_i;
    end
    if (wr_en) begin
      for (int i = MAX_BPP - 1; i > 0; i--) begin
        left_q[i] <= left_q[i-1];
        ul_q[i]   <= ul_q[i-1];
      end
      left_q[0] <= recon;
      ul_q[0]   <= up;
    end
    if (fire) begin
      if (b1_op_q.beyond) begin
        out_q.pixel_byte    <= 8'd0;
        out_q.last_in_row   <= 1'b0;
        out_q.last_in_image <= 1'b0;
        out_q.error         <= 1'b1;
      end else begin
        out_q.pixel_byte    <= b1_op_q.sticky ? 8'd0 : recon;
        out_q.last_in_row   <= b1_op_q.last_row;
        out_q.last_in_image <= b1_op_q.last_image;
        out_q.error         <= b1_op_q.sticky;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        b1_valid_q <= 1'b1;
      end else if (fire) begin
        b1_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/png_scanline_unfilter_core.sv
// ----------------------------------------------------------------------------
// png_scanline_unfilter_core
// Throughput: one item per cycle in each direction unless the queue fills or
// the output is held; filter bytes are accepted but give no result. A data
// byte passes the queue, the line store read stage and the result register.
// Reset: registers return to row_bytes 3, bytes_per_pixel 3, row_count 1 and
// the block waits for a first filter byte; the line store is not cleared.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_core import pnu_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pnu_in_item_t          in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output pnu_out_item_t         out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  // The design is split into a front end that owns the row and column
  // counters and decodes filter bytes, a short queue of classified data
  // bytes, and a back end that owns the line store, the neighbour history
  // and the result register. Either side can stall without stopping the
  // other until the queue fills or empties.

  logic [ROW_BYTES_W-1:0] row_bytes_q;
  logic [BPP_W-1:0]       bpp_q;
  logic [ROW_COUNT_W-1:0] row_count_q;

  pnu_cfg_t             cfg;
  logic [BPP_IDX_W-1:0] bpp_idx;

  logic    push, q_full, q_valid, q_pop;
  pnu_op_t push_op, q_op;

  // Register writes. An index past the end of the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_bytes_q <= ROW_BYTES_RST;
      bpp_q       <= BPP_RST;
      row_count_q <= ROW_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IDX_ROW_BYTES: row_bytes_q <= cfg_wdata_i[ROW_BYTES_W-1:0];
        CFG_IDX_BPP:       bpp_q       <= cfg_wdata_i[BPP_W-1:0];
        CFG_IDX_ROW_COUNT: row_count_q <= cfg_wdata_i[ROW_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the registers into their legal ranges before use.
  always_comb begin
    if (row_bytes_q == '0) begin
      cfg.row_bytes = ROW_BYTES_W'(1);
    end else if (row_bytes_q > ROW_BYTES_W'(MAX_ROW_BYTES)) begin
      cfg.row_bytes = ROW_BYTES_W'(MAX_ROW_BYTES);
    end else begin
      cfg.row_bytes = row_bytes_q;
    end
    if (bpp_q == '0) begin
      cfg.bpp = BPP_W'(1);
    end else if (bpp_q > BPP_W'(MAX_BPP)) begin
      cfg.bpp = BPP_W'(MAX_BPP);
    end else begin
      cfg.bpp = bpp_q;
    end
    cfg.row_count = (row_count_q == '0) ? ROW_COUNT_W'(1) : row_count_q;
  end

  // The left neighbour sits bytes_per_pixel entries back in the history.
  assign bpp_idx = BPP_IDX_W'(cfg.bpp - BPP_W'(1));

  pnu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .op_o       (push_op)
  );

  pnu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_op),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_op)
  );

  pnu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bpp_idx_i   (bpp_idx),
    .q_valid_i   (q_valid),
    .q_data_i    (q_op),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
